[rtl/i2c_mbe_pkg.sv]
`timescale 1ns / 1ps

package i2c_mbe_pkg;

  // command codes carried on the input channel
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_ADDR  = 3'd5
  } op_e;

  localparam int unsigned DelayWidth = 16;
  localparam int unsigned StepWidth  = 5;

  localparam logic [DelayWidth-1:0] DelayReset = 16'd5;

  localparam logic [StepWidth-1:0] SegsStart = 5'd4;
  localparam logic [StepWidth-1:0] SegsStop  = 5'd3;
  localparam logic [StepWidth-1:0] SegsByte  = 5'd18;
  // segment index of the acknowledge clock-low phase and the final one
  localparam logic [StepWidth-1:0] SegAckLow  = 5'd16;
  localparam logic [StepWidth-1:0] SegAckHigh = 5'd17;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data;
    logic       ack_to_send;
    logic       read_flag;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       acked;
    logic       rejected;
  } out_t;

endpackage

[rtl/i2c_mbe_if.sv]
`timescale 1ns / 1ps

interface i2c_mbe_in_if import i2c_mbe_pkg::*; ();
  logic valid;
  logic ready;
  in_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i2c_mbe_out_if import i2c_mbe_pkg::*; ();
  logic valid;
  logic ready;
  out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/i2c_master_byte_engine_core.sv]
`timescale 1ns / 1ps

// i2c master byte engine: open-drain bit sequencer for start, stop, write,
// read and address phases.
// in_i carries one time tick per transfer: the sampled sda level and an
// optional command (start, stop, write, read, address). out_o returns one
// result per tick: line releases, busy, done pulse, last read byte, last
// acknowledge and a reject flag for a command that came in while busy.
// cfg_we_i / cfg_wdata_i set the ticks per half-bit period (0 acts as 1);
// a new value is picked up at the next reload of the period counter.
// Latency: the result of a tick is on out_o the cycle after its transfer.
// Throughput: one tick per cycle; the state update and result register are
// a single short stage, so in_i stays ready while out_o drains each cycle.
// When out_o stalls, in_i takes no tick until the held result is taken.
// Reset: both lines released, idle, period 5 ticks, read byte and
// acknowledge cleared, no result pending.
module i2c_master_byte_engine_core
  import i2c_mbe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [DelayWidth-1:0] cfg_wdata_i,
  i2c_mbe_in_if.sink            in_i,
  i2c_mbe_out_if.source         out_o
);

  // configuration
  logic [DelayWidth-1:0] delay_ticks_q;

  // sequencer state
  op_e                   active_op_q, active_op_d;
  logic [StepWidth-1:0]  phase_step_q, phase_step_d;
  logic [7:0]            shift_q, shift_d;
  logic [DelayWidth-1:0] delay_count_q, delay_count_d;
  logic                  scl_q, scl_d;
  logic                  sda_q, sda_d;
  logic                  ack_seen_q, ack_seen_d;
  logic                  ack_choice_q, ack_choice_d;
  logic                  busy_q, busy_d;
  logic [7:0]            last_read_q, last_read_d;

  // result register
  logic out_valid_q;
  out_t out_q;
  out_t out_d;

  logic in_xfer;
  logic cmd_valid;

  // line levels for the first tick of segment s
  function automatic logic [1:0] enter_seg(op_e op, logic [StepWidth-1:0] s,
                                           logic [7:0] sh, logic ackc,
                                           logic scl, logic sda);
    logic scl_n;
    logic sda_n;
    scl_n = scl;
    sda_n = sda;
    unique case (op)
      OP_START: begin
        if (s == 5'd0) scl_n = 1'b0;
        else if (s == 5'd1) sda_n = 1'b1;
        else if (s == 5'd2) scl_n = 1'b1;
        else sda_n = 1'b0;
      end
      OP_STOP: begin
        if (s == 5'd0) begin
          scl_n = 1'b0;
          sda_n = 1'b0;
        end else if (s == 5'd1) scl_n = 1'b1;
        else sda_n = 1'b1;
      end
      OP_READ: begin
        if (s < SegAckLow) begin
          scl_n = s[0];
          if (s == 5'd0) sda_n = 1'b1;
        end else if (s == SegAckLow) begin
          scl_n = 1'b0;
          sda_n = ~ackc;
        end else scl_n = 1'b1;
      end
      OP_WRITE, OP_ADDR: begin
        if (s < SegAckLow) begin
          scl_n = s[0];
          if (!s[0]) sda_n = sh[7];
        end else if (s == SegAckLow) begin
          scl_n = 1'b0;
          sda_n = 1'b1;
        end else scl_n = 1'b1;
      end
      default: ;
    endcase
    return {scl_n, sda_n};
  endfunction

  function automatic logic [StepWidth-1:0] seg_count(op_e op);
    logic [StepWidth-1:0] n;
    if (op == OP_START) n = SegsStart;
    else if (op == OP_STOP) n = SegsStop;
    else n = SegsByte;
    return n;
  endfunction

  // a held result blocks the next tick unless it leaves this cycle
  assign in_xfer      = in_i.valid && in_i.ready;
  assign in_i.ready   = !out_valid_q || out_o.ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.payload = out_q;

  assign cmd_valid = (in_i.payload.command >= OP_START) &&
                     (in_i.payload.command <= OP_ADDR);

  always_comb begin
    logic [StepWidth-1:0]  nstep;
    logic [DelayWidth-1:0] cnt_dec;
    logic [DelayWidth-1:0] reload;
    logic                  rej;
    logic                  done;
    logic [1:0]            lines;

    active_op_d   = active_op_q;
    phase_step_d  = phase_step_q;
    shift_d       = shift_q;
    delay_count_d = delay_count_q;
    scl_d         = scl_q;
    sda_d         = sda_q;
    ack_seen_d    = ack_seen_q;
    ack_choice_d  = ack_choice_q;
    busy_d        = busy_q;
    last_read_d   = last_read_q;
    rej           = 1'b0;
    done          = 1'b0;
    nstep         = phase_step_q + 5'd1;
    cnt_dec       = (delay_count_q != '0) ? delay_count_q - 16'd1 : '0;
    reload        = (delay_ticks_q == '0) ? 16'd1 : delay_ticks_q;
    lines         = {scl_q, sda_q};

    if (busy_q) begin
      rej           = cmd_valid;
      delay_count_d = cnt_dec;
      if (cnt_dec == '0) begin
        // end of segment: sample, then move on
        if (active_op_q == OP_READ) begin
          if (phase_step_q < SegAckLow && phase_step_q[0]) begin
            shift_d = {shift_q[6:0], in_i.payload.sda_in};
          end else if (phase_step_q == SegAckHigh) begin
            last_read_d = shift_q;
          end
        end else if (active_op_q == OP_WRITE || active_op_q == OP_ADDR) begin
          if (phase_step_q < SegAckLow && phase_step_q[0]) begin
            shift_d = {shift_q[6:0], 1'b0};
          end else if (phase_step_q == SegAckHigh) begin
            ack_seen_d = ~in_i.payload.sda_in;
          end
        end
        if (nstep >= seg_count(active_op_q)) begin
          busy_d       = 1'b0;
          done         = 1'b1;
          active_op_d  = OP_NONE;
          phase_step_d = '0;
        end else begin
          phase_step_d  = nstep;
          lines         = enter_seg(active_op_q, nstep, shift_d, ack_choice_q,
                                    scl_q, sda_q);
          delay_count_d = reload;
        end
      end
    end else if (cmd_valid) begin
      active_op_d  = op_e'(in_i.payload.command);
      phase_step_d = '0;
      unique case (op_e'(in_i.payload.command))
        OP_WRITE: shift_d = in_i.payload.data;
        OP_ADDR:  shift_d = {in_i.payload.data[7:1], in_i.payload.read_flag};
        OP_READ: begin
          shift_d      = '0;
          ack_choice_d = in_i.payload.ack_to_send;
        end
        default: ;
      endcase
      busy_d        = 1'b1;
      lines         = enter_seg(active_op_d, '0, shift_d, ack_choice_d, scl_q, sda_q);
      delay_count_d = reload;
    end

    scl_d = lines[1];
    sda_d = lines[0];

    out_d.scl_release = scl_d;
    out_d.sda_release = sda_d;
    out_d.busy_res    = busy_d;
    out_d.done_res    = done;
    out_d.read_byte   = last_read_d;
    out_d.acked       = ack_seen_d;
    out_d.rejected    = rej;
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_ticks_q <= DelayReset;
    end else if (cfg_we_i) begin
      delay_ticks_q <= cfg_wdata_i;
    end
  end

  // sequencer state advances once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_op_q   <= OP_NONE;
      phase_step_q  <= '0;
      shift_q       <= '0;
      delay_count_q <= '0;
      scl_q         <= 1'b1;
      sda_q         <= 1'b1;
      ack_seen_q    <= 1'b0;
      ack_choice_q  <= 1'b0;
      busy_q        <= 1'b0;
      last_read_q   <= '0;
    end else if (in_xfer) begin
      active_op_q   <= active_op_d;
      phase_step_q  <= phase_step_d;
      shift_q       <= shift_d;
      delay_count_q <= delay_count_d;
      scl_q         <= scl_d;
      sda_q         <= sda_d;
      ack_seen_q    <= ack_seen_d;
      ack_choice_q  <= ack_choice_d;
      busy_q        <= busy_d;
      last_read_q   <= last_read_d;
    end
  end

  // result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= out_d;
    end
  end

  // a running sequence always has a nonzero period count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (delay_count_q != '0))
    else $error("busy with zero period count");

  // idle means no operation and segment index back at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (active_op_q == OP_NONE && phase_step_q == '0))
    else $error("idle sequencer holds stale operation");

  // done and busy never show together in a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.done_res && out_q.busy_res))
    else $error("done and busy both set");

  // a reject can only follow a tick taken while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !busy_q) |=> !out_q.rejected)
    else $error("reject flagged while idle");

endmodule
